@@ src/mttbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mttbp_pkg
// Shared types and constants for the multi-tenant token bucket policer.
// ----------------------------------------------------------------------------
package mttbp_pkg;

  localparam int unsigned TenantW    = 4;
  localparam int unsigned NumTenants = 2 ** TenantW;
  localparam int unsigned UnitW      = 16;
  localparam int unsigned CreditW    = UnitW + 1;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgFillRate  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDepth     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBurstThr  = 2'd2;

  localparam logic [UnitW-1:0] FillRateRst = 16'd120;
  localparam logic [UnitW-1:0] DepthRst    = 16'd40;
  localparam logic [UnitW-1:0] BurstThrRst = 16'd160;

  typedef struct packed {
    logic [TenantW-1:0] tenant;
    logic [UnitW-1:0]   offered;
  } in_req_t;

  typedef struct packed {
    logic [TenantW-1:0] tenant_out;
    logic [UnitW-1:0]   passed;
    logic [UnitW-1:0]   level_after;
    logic               burst_drop;
  } out_res_t;

  typedef struct packed {
    logic [UnitW-1:0] fill_rate;
    logic [UnitW-1:0] depth_limit;
    logic [UnitW-1:0] burst_threshold;
  } cfg_t;

endpackage

@@ src/mttbp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mttbp_cfg_regs
// Policer configuration registers with a plain write port.
// ----------------------------------------------------------------------------
module mttbp_cfg_regs import mttbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [UnitW-1:0]   cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFillRate: cfg_d.fill_rate       = cfg_wdata_i;
        CfgDepth:    cfg_d.depth_limit     = cfg_wdata_i;
        CfgBurstThr: cfg_d.burst_threshold = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_rate       <= FillRateRst;
      cfg_q.depth_limit     <= DepthRst;
      cfg_q.burst_threshold <= BurstThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/mttbp_bucket_core.sv @@
// ----------------------------------------------------------------------------
// mttbp_bucket_core
// Per-tenant bucket levels and the combinational policing decision.
// ----------------------------------------------------------------------------
module mttbp_bucket_core import mttbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  in_req_t  req_i,
  input  logic     upd_i,
  output out_res_t res_o
);

  logic [UnitW-1:0]   level_q [NumTenants];
  logic [UnitW-1:0]   cur_level;
  logic [CreditW-1:0] credit;
  logic [CreditW-1:0] remain;
  logic [CreditW-1:0] depth_ext;
  logic               drop;
  logic               exhaust;
  logic [UnitW-1:0]   new_level;
  logic [UnitW-1:0]   passed;

  assign cur_level = level_q[req_i.tenant];
  assign credit    = {1'b0, cur_level} + {1'b0, cfg_i.fill_rate};
  assign depth_ext = {1'b0, cfg_i.depth_limit};
  assign drop      = req_i.offered > cfg_i.burst_threshold;
  assign exhaust   = {1'b0, req_i.offered} >= credit;

  always_comb begin
    remain    = '0;
    new_level = '0;
    passed    = '0;
    if (drop) begin
      remain    = credit;
      new_level = (remain > depth_ext) ? cfg_i.depth_limit : remain[UnitW-1:0];
    end else if (exhaust) begin
      // credit <= offered here, so it fits in the unit width
      passed    = credit[UnitW-1:0];
    end else begin
      remain    = credit - {1'b0, req_i.offered};
      passed    = req_i.offered;
      new_level = (remain > depth_ext) ? cfg_i.depth_limit : remain[UnitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTenants; i++) begin
        level_q[i] <= '0;
      end
    end else if (upd_i) begin
      level_q[req_i.tenant] <= new_level;
    end
  end

  assign res_o.tenant_out  = req_i.tenant;
  assign res_o.passed      = passed;
  assign res_o.level_after = new_level;
  assign res_o.burst_drop  = drop;

endmodule

@@ src/multi_tenant_token_bucket_policer_unit.sv @@
// Registers: input, then result. Throughput: one request per cycle while the
// receiver does not stall; the bucket read, update and result capture happen
// together in the compute stage, so back-to-back requests to one tenant see
// each other's level without stalls.
// Reset: asynchronous, active low; all bucket levels clear to zero and the
// configuration registers return to their defaults.
// ----------------------------------------------------------------------------
// multi_tenant_token_bucket_policer_unit
// Top level: input register, bucket core and result register.
// ----------------------------------------------------------------------------
module multi_tenant_token_bucket_policer_unit import mttbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_req_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_res_t           out_res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [UnitW-1:0]   cfg_wdata_i
);

  cfg_t     cfg;
  in_req_t  req_q;
  logic     req_vld_q;
  out_res_t res;
  out_res_t res_q;
  logic     res_vld_q;
  logic     res_load;
  logic     req_load;

  mttbp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mttbp_bucket_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_q),
    .upd_i  (res_load),
    .res_o  (res)
  );

  assign res_load   = req_vld_q && (!res_vld_q || !out_stall_i);
  assign in_stall_o = req_vld_q && !res_load;
  assign req_load   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (req_load || res_load) begin
        req_vld_q <= req_load;
      end
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_q <= in_req_i;
    end
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_res_o   = res_q;

endmodule

@@ src/mttbp_checker.sv @@
// ----------------------------------------------------------------------------
// mttbp_checker
// Port-level checks for the policer, bound to the top level.
// ----------------------------------------------------------------------------
module mttbp_checker import mttbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  in_req_t            in_req_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  out_res_t           out_res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [UnitW-1:0]   cfg_wdata_i
);

  logic [UnitW-1:0] depth_q;
  logic             in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthRst;
    end else if (cfg_we_i && cfg_idx_i == CfgDepth) begin
      depth_q <= cfg_wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_req_i))
    else $error("request changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.burst_drop |-> out_res_o.passed == '0)
    else $error("burst drop passed traffic");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc, 2))
    else $error("result without matching request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.level_after <= depth_q)
    else $error("level above depth limit");

endmodule

bind multi_tenant_token_bucket_policer_unit mttbp_checker u_mttbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-tenant token bucket policer. A
// predictor tracks every tenant's bucket and the policer settings,
// builds the expected result for each accepted request and compares it field
// by field with the block's output. Directed cases cover reset defaults,
// exact fit, burst drop and setting extremes; random phases follow with
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import mttbp_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned PhaseReqs  = 138;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_req_t              in_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_res_t             out_res;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = '0;
  logic [UnitW-1:0]     cfg_wdata = '0;

  logic [UnitW-1:0]     rate_cfg = FillRateRst;
  logic [UnitW-1:0]     depth_cfg = DepthRst;
  logic [UnitW-1:0]     thr_cfg = BurstThrRst;
  logic [UnitW-1:0]     bucket_lvl [NumTenants];
  out_res_t             expected_grants [$];
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int unsigned          mismatch_cnt = 0;
  int unsigned          cycle_cnt = 0;

  multi_tenant_token_bucket_policer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Police one slot and advance that tenant's bucket.
  function automatic out_res_t police_slot(input in_req_t req);
    logic [CreditW-1:0] credit;
    logic [CreditW-1:0] left;
    out_res_t           res;
    credit = {1'b0, bucket_lvl[req.tenant]} + {1'b0, rate_cfg};
    res.tenant_out = req.tenant;
    res.passed     = '0;
    res.burst_drop = 1'b0;
    if (req.offered > thr_cfg) begin
      res.burst_drop = 1'b1;
      left = credit;
    end else if ({1'b0, req.offered} >= credit) begin
      res.passed = credit[UnitW-1:0];
      left = '0;
    end else begin
      res.passed = req.offered;
      left = credit - {1'b0, req.offered};
    end
    res.level_after = (left > {1'b0, depth_cfg}) ? depth_cfg : left[UnitW-1:0];
    bucket_lvl[req.tenant] = res.level_after;
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports)
          $display("unexpected result: %p", out_res);
      end else begin
        want = expected_grants.pop_front();
        if (out_res.tenant_out !== want.tenant_out || out_res.passed !== want.passed ||
            out_res.level_after !== want.level_after ||
            out_res.burst_drop !== want.burst_drop) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("mismatch: tenant %0d/%0d passed %0d/%0d level %0d/%0d drop %0d/%0d",
                     want.tenant_out, out_res.tenant_out, want.passed, out_res.passed,
                     want.level_after, out_res.level_after, want.burst_drop,
                     out_res.burst_drop);
        end
      end
    end
  end

  task automatic send_req(input logic [TenantW-1:0] tenant, input logic [UnitW-1:0] offered);
    in_req_t req;
    req.tenant  = tenant;
    req.offered = offered;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    expected_grants.push_back(police_slot(req));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high; program_regs lowers it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [UnitW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CfgFillRate: rate_cfg  = data;
      CfgDepth:    depth_cfg = data;
      CfgBurstThr: thr_cfg   = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [UnitW-1:0] fill, depth, thr);
    write_reg(CfgSpare, 16'($urandom));
    write_reg(CfgFillRate, fill);
    write_reg(CfgDepth, depth);
    write_reg(CfgBurstThr, thr);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [UnitW-1:0] pick_offer(input logic [TenantW-1:0] tenant);
    int credit;
    credit = int'(bucket_lvl[tenant]) + int'(rate_cfg);
    case ($urandom_range(9))
      5: return (credit > 65535) ? 16'($urandom) : 16'(credit);
      6: return thr_cfg;
      7: return (thr_cfg == 16'hFFFF) ? thr_cfg : thr_cfg + 16'd1;
      8: return 16'($urandom);
      9: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, int'(thr_cfg)));
    endcase
  endfunction

  task automatic run_phase(input int idle, input int stall, input bit wide_cfg,
                           input bit mid_pause);
    logic [TenantW-1:0] tenant;
    drain();
    if (wide_cfg)
      program_regs(16'($urandom), 16'($urandom), 16'($urandom));
    else
      program_regs(16'($urandom_range(0, 200)), 16'($urandom_range(0, 500)),
                   16'($urandom_range(0, 600)));
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < PhaseReqs; i++) begin
      if (mid_pause && i == PhaseReqs / 2)
        drain();
      tenant = $urandom_range(1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      send_req(tenant, pick_offer(tenant));
    end
  endtask

  task automatic test_reset_defaults();
    idle_pct  = 0;
    stall_pct = 0;
    send_req(4'd0, 16'd0);
    send_req(4'd0, 16'd160);
    send_req(4'd0, 16'd161);
    send_req(4'd0, 16'hFFFF);
    send_req(4'd15, 16'd100);
    send_req(4'd15, 16'd1);
  endtask

  task automatic test_config_extremes();
    drain();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(4'd3, 16'd0);
    send_req(4'd3, 16'd0);
    send_req(4'd3, 16'hFFFF);
    send_req(4'd10, 16'hFFFF);
    drain();
    // tenant 3 still holds a level far above the new depth
    program_regs(16'd0, 16'd0, 16'd0);
    send_req(4'd3, 16'd0);
    send_req(4'd3, 16'd0);
    send_req(4'd5, 16'd1);
    drain();
    program_regs(16'd100, 16'd1000, 16'd50);
    send_req(4'd7, 16'd0);
    send_req(4'd7, 16'd0);
    drain();
    program_regs(16'd100, 16'd20, 16'd50);
    send_req(4'd7, 16'd60);
  endtask

  task automatic test_back_to_back();
    run_phase(0, 0, 1'b0, 1'b0);
  endtask

  task automatic test_sender_gaps();
    run_phase(60, 0, 1'b0, 1'b1);
  endtask

  task automatic test_receiver_stalls();
    run_phase(0, 60, 1'b0, 1'b0);
  endtask

  task automatic test_mixed_idling();
    run_phase(8, 8, 1'b0, 1'b0);
  endtask

  task automatic test_wide_config();
    run_phase(8, 8, 1'b1, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < NumTenants; i++) bucket_lvl[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_wide_config();
    drain();
    if (mismatch_cnt == 0 && expected_grants.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/mttbp_pkg.sv
src/mttbp_cfg_regs.sv
src/mttbp_bucket_core.sv
src/multi_tenant_token_bucket_policer_unit.sv
src/mttbp_checker.sv
dv/tb_top.sv
